/* hw/rtl/b64e_pkg.sv */
package b64e_pkg;

  // Item codes
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_FINAL = 1'b1;

  // Line geometry
  localparam int LINE_CHARS   = 76;
  localparam int GROUP_CHARS  = 4;
  localparam int LINE_W       = 7;
  localparam int LAST_GRP_POS = LINE_CHARS - GROUP_CHARS;

  // Characters
  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [7:0] CR_CHAR  = 8'h0D;
  localparam logic [7:0] LF_CHAR  = 8'h0A;
  localparam logic [7:0] ERR_CHAR = 8'h00;

  localparam logic [31:0] MAX_TOTAL_RESET = 32'hFFFF_FFFF;

  // Register map
  localparam int PADDR_W = 3;
  localparam logic REG_MAX_TOTAL = 1'b0;

  // Job queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Result step counter: up to four characters plus CR LF
  localparam int STEP_W = 3;

  typedef enum logic [1:0] {
    JOB_ERR,
    JOB_GROUP,
    JOB_CRLF
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [23:0] blk;
    logic [1:0]  nbytes;
    logic        crlf;
  } job_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } q_stat_t;

  typedef struct packed {
    logic [1:0]        pend_count;
    logic [LINE_W-1:0] line_count;
  } front_stat_t;

  // Standard alphabet lookup for one sextet
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] v8;
    v8 = {2'b00, v};
    if (v < 6'd26) begin
      b64_char = 8'(8'd65 + v8);
    end else if (v < 6'd52) begin
      b64_char = 8'(8'd97 + v8 - 8'd26);
    end else if (v < 6'd62) begin
      b64_char = 8'(8'd48 + v8 - 8'd52);
    end else if (v == 6'd62) begin
      b64_char = 8'h2B;
    end else begin
      b64_char = 8'h2F;
    end
  endfunction

endpackage

/* hw/rtl/b64e_if.sv */
interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface b64e_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       error;
  logic       last;

  modport source (output valid, output out_char, output error, output last, input ready);
  modport sink   (input valid, input out_char, input error, input last, output ready);
endinterface

/* hw/rtl/b64e_front.sv */
module b64e_front
  import b64e_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  b64e_byte_if.sink     byte_ch,
  input  logic [31:0]   max_total,
  input  q_stat_t       q_stat,
  output logic          push,
  output job_t          job,
  output front_stat_t   stat
);

  logic [7:0]        pend0, pend1, pend0_next, pend1_next;
  logic [1:0]        pend_count, pend_count_next;
  logic [LINE_W-1:0] line_count, line_count_next;
  logic [31:0]       total, total_next;
  logic              accept;

  assign byte_ch.ready = !q_stat.full;
  assign accept        = byte_ch.valid && byte_ch.ready;
  assign stat.pend_count = pend_count;
  assign stat.line_count = line_count;

  // Classify the beat and build a job for the back end
  always_comb begin
    pend0_next      = pend0;
    pend1_next      = pend1;
    pend_count_next = pend_count;
    line_count_next = line_count;
    total_next      = total;
    push            = 1'b0;
    job.kind        = JOB_GROUP;
    job.blk         = {pend0, pend1, byte_ch.data_byte};
    job.nbytes      = 2'd3;
    job.crlf        = 1'b0;
    if (accept) begin
      case (byte_ch.opcode)
        OP_DATA: begin
          if (total >= max_total) begin
            push     = 1'b1;
            job.kind = JOB_ERR;
          end else begin
            total_next = total + 32'd1;
            if (pend_count < 2'd2) begin
              if (pend_count[0]) begin
                pend1_next = byte_ch.data_byte;
              end else begin
                pend0_next = byte_ch.data_byte;
              end
              pend_count_next = pend_count + 2'd1;
            end else begin
              push            = 1'b1;
              pend_count_next = 2'd0;
              if (line_count == LINE_W'(LAST_GRP_POS)) begin
                job.crlf        = 1'b1;
                line_count_next = '0;
              end else begin
                line_count_next = line_count + LINE_W'(GROUP_CHARS);
              end
            end
          end
        end
        OP_FINAL: begin
          pend_count_next = 2'd0;
          line_count_next = '0;
          job.crlf        = 1'b1;
          job.nbytes      = pend_count;
          job.blk         = {pend0, (pend_count > 2'd1) ? pend1 : 8'd0, 8'd0};
          if (pend_count != 2'd0) begin
            push = 1'b1;
          end else if (line_count != '0) begin
            push     = 1'b1;
            job.kind = JOB_CRLF;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pend0 <= pend0_next;
    pend1 <= pend1_next;
    if (rst) begin
      pend_count <= '0;
      line_count <= '0;
      total      <= '0;
    end else begin
      pend_count <= pend_count_next;
      line_count <= line_count_next;
      total      <= total_next;
    end
  end

endmodule

/* hw/rtl/b64e_queue.sv */
module b64e_queue
  import b64e_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head,
  output q_stat_t stat
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head       = mem[rd_ptr];
  assign stat.count = count;
  assign stat.full  = (count == QCNT_W'(QDEPTH));
  assign stat.empty = (count == '0);

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/b64e_back.sv */
module b64e_back
  import b64e_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  job_t        head,
  input  q_stat_t     q_stat,
  output logic        pop,
  b64e_char_if.source char_ch
);

  logic [STEP_W-1:0] step, step_next;
  logic [STEP_W-1:0] n_results;
  logic              out_valid, out_valid_next;
  logic [7:0]        out_char, char_next;
  logic              out_err, out_last, last_next;
  logic              load;

  assign char_ch.valid    = out_valid;
  assign char_ch.out_char = out_char;
  assign char_ch.error    = out_err;
  assign char_ch.last     = out_last;

  assign load = !q_stat.empty && (!out_valid || char_ch.ready);

  // Number of result beats for the job at the head
  always_comb begin
    case (head.kind)
      JOB_ERR:   n_results = STEP_W'(1);
      JOB_GROUP: n_results = head.crlf ? STEP_W'(6) : STEP_W'(4);
      JOB_CRLF:  n_results = STEP_W'(2);
      default:   n_results = STEP_W'(1);
    endcase
  end

  // Character for the current step
  always_comb begin
    if (head.kind == JOB_ERR) begin
      char_next = ERR_CHAR;
    end else if (head.kind == JOB_GROUP && step < STEP_W'(GROUP_CHARS)) begin
      case (step[1:0])
        2'd0: char_next = b64_char(head.blk[23:18]);
        2'd1: char_next = b64_char(head.blk[17:12]);
        2'd2: char_next = (head.nbytes > 2'd1) ? b64_char(head.blk[11:6]) : PAD_CHAR;
        2'd3: char_next = (head.nbytes > 2'd2) ? b64_char(head.blk[5:0]) : PAD_CHAR;
        default: char_next = PAD_CHAR;
      endcase
    end else begin
      // line break pair sits on even/odd steps
      char_next = step[0] ? LF_CHAR : CR_CHAR;
    end
  end

  assign last_next = (step == n_results - STEP_W'(1));
  assign pop       = load && last_next;

  always_comb begin
    step_next      = step;
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
      step_next      = last_next ? '0 : step + STEP_W'(1);
    end else if (char_ch.ready) begin
      out_valid_next = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= char_next;
      out_err  <= (head.kind == JOB_ERR);
      out_last <= last_next;
    end
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* hw/rtl/base64_mime_stream_encoder_unit.sv */
// Channel   Role    Beat contents
// byte_ch   sink    opcode (data / finalize), data_byte
// char_ch   source  out_char, error, last
// apb       slave   max_total_bytes at byte address 0
//
// A byte beat is taken every cycle while the two-entry job queue has room.
// The back end sends one result beat per cycle from its output register while
// char_ch is ready; a three-byte group yields four to six result beats.
// Reset (rst, synchronous) clears counters, queue and output valid; the
// limit register returns to all ones. Stalls on char_ch back up the queue.
module base64_mime_stream_encoder_unit
  import b64e_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  b64e_byte_if.sink          byte_ch,
  b64e_char_if.source        char_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [31:0] max_total;
  logic        push, pop;
  job_t        push_job, head;
  q_stat_t     q_stat;
  front_stat_t f_stat;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_TOTAL) ? max_total : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_total <= MAX_TOTAL_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_TOTAL) begin
      max_total <= pwdata;
    end
  end

  b64e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .max_total (max_total),
    .q_stat    (q_stat),
    .push      (push),
    .job       (push_job),
    .stat      (f_stat)
  );

  b64e_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  b64e_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_stat  (q_stat),
    .pop     (pop),
    .char_ch (char_ch)
  );

  // Checks
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= QCNT_W'(QDEPTH) && !(push && q_stat.full))
    else $error("job queue overflow");

  a_line_align: assert property (@(posedge clk) disable iff (rst)
    f_stat.line_count < LINE_W'(LINE_CHARS) && f_stat.line_count[1:0] == 2'b00)
    else $error("line position off group grid");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    byte_ch.valid && byte_ch.ready && byte_ch.opcode == OP_FINAL
    |=> f_stat.pend_count == 2'd0 && f_stat.line_count == '0)
    else $error("finalize left state behind");

  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    char_ch.valid && char_ch.error |-> char_ch.last && char_ch.out_char == ERR_CHAR)
    else $error("malformed error beat");

endmodule
